/* rtl/ilt_pkg.sv */
// shared types and constants for the indexed list table
// used by the channel interfaces, the cell, the selector and the top level
package ilt_pkg;

   // field widths of the request and response beats
   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int FIDX_W   = 6;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 7;

   // cells gathered by one first-hit group in the selector
   localparam int GROUP_SIZE = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH        = 3'd0,
      CMD_POP         = 3'd1,
      CMD_INSERT      = 3'd2,
      CMD_ERASE       = 3'd3,
      CMD_ERASE_RANGE = 3'd4,
      CMD_FIND        = 3'd5,
      CMD_GET         = 3'd6,
      CMD_CLEAR       = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_ERROR = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // action broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ERASE,
      CELL_FIND,
      CELL_GET
   } cell_op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ERASING,
      S_SCAN,
      S_FINISH
   } state_type;

endpackage

/* rtl/ilt_if.sv */
// request and response channels of the indexed list table
// depends on ilt_pkg for the field widths
interface ilt_req_if;
   logic                           valid;
   logic                           ready;
   logic [ilt_pkg::CMD_W-1:0]      command;
   logic [ilt_pkg::VALUE_W-1:0]    value;
   logic [ilt_pkg::FIDX_W-1:0]     index;
   logic [ilt_pkg::FIDX_W-1:0]     right_index;

   modport source (output valid, command, value, index, right_index, input ready);
   modport sink   (input valid, command, value, index, right_index, output ready);
endinterface

interface ilt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ilt_pkg::STATUS_W-1:0]   status;
   logic [ilt_pkg::DATA_W-1:0]     data;
   logic [ilt_pkg::FIDX_W-1:0]     position;
   logic                           found;
   logic [ilt_pkg::COUNT_W-1:0]    count;

   modport source (output valid, status, data, position, found, count, input ready);
   modport sink   (input valid, status, data, position, found, count, output ready);
endinterface

/* rtl/ilt_cell.sv */
// one storage cell of the list chain: holds a word, takes a neighbour's word
// on shifts and flags a hit for find or get; depends on ilt_pkg
module ilt_cell #(
   parameter int POS       = 0,
   parameter int ELEM_BITS = 32,
   parameter int CNT_W     = 7
) (
   input  logic                  clock,
   input  ilt_pkg::cell_op_type  op,
   input  logic [CNT_W-1:0]      anchor,
   input  logic [CNT_W-1:0]      limit,
   input  logic [ELEM_BITS-1:0]  value,
   input  logic [ELEM_BITS-1:0]  left_data,
   input  logic [ELEM_BITS-1:0]  right_data,
   output logic [ELEM_BITS-1:0]  data_out,
   output logic                  hit_out
);

   localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);

   logic [ELEM_BITS-1:0] data_ff, data_in;
   logic                 hit_ff, hit_in;

   // next word and hit flag for this position
   always_comb begin
      data_in = data_ff;
      hit_in  = 1'b0;
      case (op)
         ilt_pkg::CELL_INSERT: begin
            if (POS_C == anchor) begin
               data_in = value;
            end else if (POS_C > anchor) begin
               data_in = left_data;
            end
         end
         ilt_pkg::CELL_ERASE: begin
            if (POS_C >= anchor) begin
               data_in = right_data;
            end
         end
         ilt_pkg::CELL_FIND: begin
            hit_in = (data_ff == value) && (POS_C < limit);
         end
         ilt_pkg::CELL_GET: begin
            hit_in = (POS_C == anchor);
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
   end

   assign data_out = data_ff;
   assign hit_out  = hit_ff;

endmodule

/* rtl/ilt_select.sv */
// first-hit selector over the cell chain: registered groups of eight,
// then a pick of the first hit group; depends on ilt_pkg
module ilt_select #(
   parameter int DEPTH     = 64,
   parameter int ELEM_BITS = 32,
   parameter int IDX_W     = 6
) (
   input  logic                  clock,
   input  logic                  capture,
   input  logic                  hits [DEPTH],
   input  logic [ELEM_BITS-1:0]  words [DEPTH],
   output logic                  sel_hit,
   output logic [IDX_W-1:0]      sel_pos,
   output logic [ELEM_BITS-1:0]  sel_data
);

   localparam int GSIZE = ilt_pkg::GROUP_SIZE;
   localparam int NGRP  = (DEPTH + GSIZE - 1) / GSIZE;
   localparam int PAD   = NGRP * GSIZE;
   localparam int LOC_W = $clog2(GSIZE);

   logic                 pad_hit  [PAD];
   logic [ELEM_BITS-1:0] pad_word [PAD];

   logic                 grp_hit_ff  [NGRP];
   logic                 grp_hit_in  [NGRP];
   logic [LOC_W-1:0]     grp_loc_ff  [NGRP];
   logic [LOC_W-1:0]     grp_loc_in  [NGRP];
   logic [ELEM_BITS-1:0] grp_data_ff [NGRP];
   logic [ELEM_BITS-1:0] grp_data_in [NGRP];

   // pad the chain out to whole groups
   always_comb begin
      for (int k = 0; k < PAD; k++) begin
         if (k < DEPTH) begin
            pad_hit[k]  = hits[k];
            pad_word[k] = words[k];
         end else begin
            pad_hit[k]  = 1'b0;
            pad_word[k] = '0;
         end
      end
   end

   // first hit inside each group, lowest position wins
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_hit_in[g]  = 1'b0;
         grp_loc_in[g]  = '0;
         grp_data_in[g] = '0;
         for (int j = GSIZE - 1; j >= 0; j--) begin
            if (pad_hit[g * GSIZE + j]) begin
               grp_hit_in[g]  = 1'b1;
               grp_loc_in[g]  = LOC_W'(j);
               grp_data_in[g] = pad_word[g * GSIZE + j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         grp_hit_ff  <= grp_hit_in;
         grp_loc_ff  <= grp_loc_in;
         grp_data_ff <= grp_data_in;
      end
   end

   // first hit group
   always_comb begin
      sel_hit  = 1'b0;
      sel_pos  = '0;
      sel_data = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_hit_ff[g]) begin
            sel_hit  = 1'b1;
            sel_pos  = IDX_W'(g * GSIZE + int'(grp_loc_ff[g]));
            sel_data = grp_data_ff[g];
         end
      end
   end

endmodule

/* rtl/indexed_list_table_top.sv */
// indexed list table: ordered word list held in a chain of cells
// push, pop, insert, erase, clear and rejected commands load the response on acceptance;
//   find and get pass the cell hit register, the group register and the output register;
//   erase range shifts the chain one word per cycle, or truncates a range past the end
// throughput: one command in flight; next beat taken as the last result leaves
// reset clears the count and the control; stored words are not reset
module indexed_list_table_top #(
   parameter int DEPTH     = 64,
   parameter int ELEM_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   ilt_req_if.sink      req_bus,
   ilt_rsp_if.source    rsp_bus
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = (CNT_W > ilt_pkg::FIDX_W) ? CNT_W : ilt_pkg::FIDX_W;

   ilt_pkg::state_type   state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   ilt_pkg::cmd_type     cmd_ff;
   logic [CNT_W-1:0]     idx_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ilt_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic [ilt_pkg::DATA_W-1:0]      rsp_data_ff;
   logic [ilt_pkg::FIDX_W-1:0]      rsp_position_ff;
   logic                            rsp_found_ff;
   logic [ilt_pkg::COUNT_W-1:0]     rsp_count_ff;

   logic                  rsp_load;
   ilt_pkg::status_type   status_in;
   logic [ilt_pkg::DATA_W-1:0]   data_in;
   logic [ilt_pkg::FIDX_W-1:0]   position_in;
   logic                  found_in;

   ilt_pkg::cell_op_type  cell_op;
   logic [CNT_W-1:0]      anchor;
   logic                  capture;
   logic                  accept;
   logic                  slot_free;
   logic                  full;
   ilt_pkg::cmd_type      req_cmd;
   logic [CMP_W-1:0]      req_idx, req_ridx, cnt_cmp;
   logic [ELEM_BITS-1:0]  req_val;

   logic                  cell_hit  [DEPTH];
   logic [ELEM_BITS-1:0]  cell_word [DEPTH];
   logic                  sel_hit;
   logic [IDX_W-1:0]      sel_pos;
   logic [ELEM_BITS-1:0]  sel_data;

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign accept    = req_bus.valid && req_bus.ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign req_cmd   = ilt_pkg::cmd_type'(req_bus.command);
   assign req_idx   = CMP_W'(req_bus.index);
   assign req_ridx  = CMP_W'(req_bus.right_index);
   assign cnt_cmp   = CMP_W'(count_ff);
   assign req_val   = ELEM_BITS'(req_bus.value);

   // command sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rem_in      = rem_ff;
      cell_op     = ilt_pkg::CELL_HOLD;
      anchor      = '0;
      capture     = 1'b0;
      rsp_load    = 1'b0;
      status_in   = ilt_pkg::ST_OK;
      data_in     = '0;
      position_in = '0;
      found_in    = 1'b0;
      req_bus.ready = 1'b0;
      case (state_ff)
         ilt_pkg::S_IDLE: begin
            req_bus.ready = slot_free;
            if (req_bus.valid && slot_free) begin
               rsp_load = 1'b1;
               case (req_cmd)
                  ilt_pkg::CMD_PUSH: begin
                     if (full) begin
                        status_in = ilt_pkg::ST_FULL;
                     end else begin
                        cell_op  = ilt_pkg::CELL_INSERT;
                        anchor   = count_ff;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ilt_pkg::CMD_POP: begin
                     if (count_ff == '0) begin
                        status_in = ilt_pkg::ST_ERROR;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  ilt_pkg::CMD_INSERT: begin
                     if (req_idx >= cnt_cmp) begin
                        status_in = ilt_pkg::ST_ERROR;
                     end else if (full) begin
                        status_in = ilt_pkg::ST_FULL;
                     end else begin
                        cell_op  = ilt_pkg::CELL_INSERT;
                        anchor   = CNT_W'(req_idx);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ilt_pkg::CMD_ERASE: begin
                     if (req_idx >= cnt_cmp) begin
                        status_in = ilt_pkg::ST_ERROR;
                     end else begin
                        cell_op  = ilt_pkg::CELL_ERASE;
                        anchor   = CNT_W'(req_idx);
                        count_in = count_ff - 1'b1;
                     end
                  end
                  ilt_pkg::CMD_ERASE_RANGE: begin
                     if (req_idx > req_ridx || req_idx >= cnt_cmp) begin
                        status_in = ilt_pkg::ST_ERROR;
                     end else if (req_ridx >= cnt_cmp) begin
                        count_in = CNT_W'(req_idx);
                     end else begin
                        rsp_load = 1'b0;
                        rem_in   = CNT_W'(req_ridx - req_idx + 1'b1);
                        state_in = ilt_pkg::S_ERASING;
                     end
                  end
                  ilt_pkg::CMD_FIND: begin
                     rsp_load = 1'b0;
                     cell_op  = ilt_pkg::CELL_FIND;
                     state_in = ilt_pkg::S_SCAN;
                  end
                  ilt_pkg::CMD_GET: begin
                     if (req_idx >= cnt_cmp) begin
                        status_in = ilt_pkg::ST_ERROR;
                     end else begin
                        rsp_load = 1'b0;
                        cell_op  = ilt_pkg::CELL_GET;
                        anchor   = CNT_W'(req_idx);
                        state_in = ilt_pkg::S_SCAN;
                     end
                  end
                  default: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         // one word removed at the left end of the range per cycle
         ilt_pkg::S_ERASING: begin
            cell_op  = ilt_pkg::CELL_ERASE;
            anchor   = idx_ff;
            count_in = count_ff - 1'b1;
            rem_in   = rem_ff - 1'b1;
            if (rem_ff == CNT_W'(1)) begin
               state_in = ilt_pkg::S_FINISH;
            end
         end
         ilt_pkg::S_SCAN: begin
            capture  = 1'b1;
            state_in = ilt_pkg::S_FINISH;
         end
         ilt_pkg::S_FINISH: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ilt_pkg::S_IDLE;
               if (cmd_ff == ilt_pkg::CMD_GET) begin
                  data_in = ilt_pkg::DATA_W'(sel_data);
               end
               if (cmd_ff == ilt_pkg::CMD_FIND) begin
                  found_in    = sel_hit;
                  position_in = ilt_pkg::FIDX_W'(sel_pos);
               end
            end
         end
         default: begin
            state_in = ilt_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilt_pkg::S_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // command fields kept for multi-cycle work
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         idx_ff <= CNT_W'(req_idx);
      end
   end

   // response beat register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff   <= status_in;
         rsp_data_ff     <= data_in;
         rsp_position_ff <= position_in;
         rsp_found_ff    <= found_in;
         rsp_count_ff    <= ilt_pkg::COUNT_W'(count_in);
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.status   = rsp_status_ff;
   assign rsp_bus.data     = rsp_data_ff;
   assign rsp_bus.position = rsp_position_ff;
   assign rsp_bus.found    = rsp_found_ff;
   assign rsp_bus.count    = rsp_count_ff;

   // chain of cells, each wired to its neighbours
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [ELEM_BITS-1:0] left_word, right_word;
      if (g == 0) begin : g_first
         assign left_word = cell_word[g];
      end else begin : g_mid_left
         assign left_word = cell_word[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_word = cell_word[g];
      end else begin : g_mid_right
         assign right_word = cell_word[g+1];
      end
      ilt_cell #(
         .POS       (g),
         .ELEM_BITS (ELEM_BITS),
         .CNT_W     (CNT_W)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .anchor     (anchor),
         .limit      (count_ff),
         .value      (req_val),
         .left_data  (left_word),
         .right_data (right_word),
         .data_out   (cell_word[g]),
         .hit_out    (cell_hit[g])
      );
   end

   ilt_select #(
      .DEPTH     (DEPTH),
      .ELEM_BITS (ELEM_BITS),
      .IDX_W     (IDX_W)
   ) u_select (
      .clock    (clock),
      .capture  (capture),
      .hits     (cell_hit),
      .words    (cell_word),
      .sel_hit  (sel_hit),
      .sel_pos  (sel_pos),
      .sel_data (sel_data)
   );

endmodule
